// File: rtl/fflg_pkg.sv
// ============================================================================
// fflg_pkg: shared types, codes and constant tables
// Register indexes, error codes, binomial and coverage tables used by the
// fractional factorial level generator.
// ============================================================================
package fflg_pkg;

    localparam int MAX_BASE_FACTORS = 12;
    localparam int NF_W   = 13;
    localparam int RES_W  = 3;
    localparam int IDX_W  = 12;
    localparam int K_W    = 4;
    localparam int MASK_W = 12;
    localparam int ERR_W  = 2;
    localparam int OPD_W  = 13;
    localparam int BIN_W  = 10;

    localparam logic [K_W-1:0] K_LIMIT = 4'(MAX_BASE_FACTORS);

    localparam logic REG_NUM_FACTORS = 1'b0;
    localparam logic REG_RESOLUTION  = 1'b1;

    localparam logic [NF_W-1:0]  NUM_FACTORS_RST = 13'd1;
    localparam logic [RES_W-1:0] RESOLUTION_RST  = 3'd4;
    localparam logic [RES_W-1:0] RESOLUTION_FIVE = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_K      = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SAMPLE = 2'd2;
    localparam logic [ERR_W-1:0] ERR_COLUMN = 2'd3;

    typedef struct packed {
        logic [NF_W-1:0]  num_factors;
        logic [RES_W-1:0] resolution;
    } cfg_t;

    typedef struct packed {
        logic [OPD_W-1:0] a;
        logic [OPD_W-1:0] b;
    } unit_req_t;

    typedef struct packed {
        logic [OPD_W-1:0] diff;
        logic             lt;
    } unit_rsp_t;

    localparam logic [BIN_W-1:0] BINOM [13][13] = '{
        '{10'd1, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd1,  10'd0,  10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd2,  10'd1,  10'd0,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd3,  10'd3,  10'd1,   10'd0,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd4,  10'd6,  10'd4,   10'd1,   10'd0,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd5,  10'd10, 10'd10,  10'd5,   10'd1,   10'd0,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd6,  10'd15, 10'd20,  10'd15,  10'd6,   10'd1,
          10'd0, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd7,  10'd21, 10'd35,  10'd35,  10'd21,  10'd7,
          10'd1, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd8,  10'd28, 10'd56,  10'd70,  10'd56,  10'd28,
          10'd8, 10'd1,  10'd0,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd9,  10'd36, 10'd84,  10'd126, 10'd126, 10'd84,
          10'd36, 10'd9, 10'd1,  10'd0,   10'd0,   10'd0},
        '{10'd1, 10'd10, 10'd45, 10'd120, 10'd210, 10'd252, 10'd210,
          10'd120, 10'd45, 10'd10, 10'd1, 10'd0,   10'd0},
        '{10'd1, 10'd11, 10'd55, 10'd165, 10'd330, 10'd462, 10'd462,
          10'd330, 10'd165, 10'd55, 10'd11, 10'd1, 10'd0},
        '{10'd1, 10'd12, 10'd66, 10'd220, 10'd495, 10'd792, 10'd924,
          10'd792, 10'd495, 10'd220, 10'd66, 10'd12, 10'd1}
    };

    function automatic logic [BIN_W-1:0] binom(input logic [K_W-1:0] n,
                                                input logic [K_W-1:0] r);
        logic [BIN_W-1:0] v;
        if (n > K_LIMIT || r > n)
            v = '0;
        else
            v = BINOM[n][r];
        return v;
    endfunction

    // k + sum of C(k,j) for j from resolution-1 up to k
    function automatic logic [NF_W-1:0] coverage(input logic [K_W-1:0] k,
                                                  input logic res5);
        logic [NF_W-1:0] v;
        case ({res5, k})
            {1'b0, 4'd3}:  v = 13'd4;
            {1'b0, 4'd4}:  v = 13'd9;
            {1'b0, 4'd5}:  v = 13'd21;
            {1'b0, 4'd6}:  v = 13'd48;
            {1'b0, 4'd7}:  v = 13'd106;
            {1'b0, 4'd8}:  v = 13'd227;
            {1'b0, 4'd9}:  v = 13'd475;
            {1'b0, 4'd10}: v = 13'd978;
            {1'b0, 4'd11}: v = 13'd1992;
            {1'b0, 4'd12}: v = 13'd4029;
            {1'b1, 4'd4}:  v = 13'd5;
            {1'b1, 4'd5}:  v = 13'd11;
            {1'b1, 4'd6}:  v = 13'd28;
            {1'b1, 4'd7}:  v = 13'd71;
            {1'b1, 4'd8}:  v = 13'd171;
            {1'b1, 4'd9}:  v = 13'd391;
            {1'b1, 4'd10}: v = 13'd858;
            {1'b1, 4'd11}: v = 13'd1827;
            {1'b1, 4'd12}: v = 13'd3809;
            default:       v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/fractional_factorial_level_gen_unit.sv
// ============================================================================
// fractional_factorial_level_gen_unit: two-level fractional factorial entry
// Finds the base factor count, unranks the generator of a column and returns
// the level of one design-matrix entry per input beat.
// ============================================================================
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: sample_index, column_index
//  m_*      out  m_tvalid/m_tready  m_tdata: level, base_factors, mask, error
//  apb      in   psel/penable       paddr 0 num_factors, 4 resolution
//
//  One beat runs a base-factor search of up to ten steps, a size search of
//  up to ten steps and a position walk of up to thirteen steps, all through
//  the one subtract/compare unit.
//  s_tready is high only while the sequencer is idle.
//  The result register frees the sequencer once loaded; a stalled m_tready
//  holds the next result in the final step. Reset clears control state.
// ============================================================================
module fractional_factorial_level_gen_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] sample_index, [23:12] column_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] level, [4:1] base_factors,
                                   // [16:5] generator_mask, [18:17] error_code
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_KSRCH  = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_SIZE   = 6'b001000,
        ST_POS    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    fflg_pkg::cfg_t      cfg;
    fflg_pkg::unit_req_t unit_req;
    fflg_pkg::unit_rsp_t unit_rsp;

    state_t                        state_reg, state_next;
    logic [fflg_pkg::IDX_W-1:0]    sample_reg, sample_next;
    logic [fflg_pkg::IDX_W-1:0]    column_reg, column_next;
    logic [fflg_pkg::K_W-1:0]      k_reg, k_next;
    logic [fflg_pkg::K_W-1:0]      s_reg, s_next;
    logic [fflg_pkg::K_W-1:0]      p_reg, p_next;
    logic [fflg_pkg::K_W:0]        x_reg, x_next;
    logic [fflg_pkg::IDX_W-1:0]    g_reg, g_next;
    logic [fflg_pkg::MASK_W-1:0]   mask_reg, mask_next;
    logic                          gen_reg, gen_next;
    logic [fflg_pkg::ERR_W-1:0]    err_reg, err_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [23:0]                   m_tdata_reg, m_tdata_next;

    logic                          res5;
    logic [fflg_pkg::K_W-1:0]      res_min1;
    logic [fflg_pkg::K_W-1:0]      pos_n;
    logic [fflg_pkg::K_W-1:0]      pos_r;
    logic                          sample_oor;
    logic                          is_base;
    logic                          take;
    logic                          out_free;
    logic [fflg_pkg::MASK_W-1:0]   kmask;
    logic [fflg_pkg::IDX_W-1:0]    sample_shift;
    logic                          level_val;
    logic [fflg_pkg::MASK_W-1:0]   out_mask;
    logic [fflg_pkg::K_W-1:0]      out_k;

    fflg_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fflg_sub_unit u_unit
    (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    assign res5     = (cfg.resolution == fflg_pkg::RESOLUTION_FIVE);
    assign res_min1 = res5 ? 4'd4 : 4'd3;
    assign pos_n    = k_reg - x_reg[fflg_pkg::K_W-1:0] - 4'd1;
    assign pos_r    = s_reg - p_reg - 4'd1;

    assign sample_oor   = ((sample_reg >> k_reg) != '0);
    assign is_base      = (column_reg < {8'b0, k_reg});
    assign take         = (x_reg >= {1'b0, k_reg}) || unit_rsp.lt;
    assign kmask        = ~(12'hFFF << k_reg);
    assign sample_shift = sample_reg >> column_reg[fflg_pkg::K_W-1:0];
    assign out_free     = !m_tvalid_reg || m_tready;

    // Select operands for the shared unit
    always_comb
    begin
        unit_req.a = {1'b0, g_reg};
        unit_req.b = '0;
        unique case (state_reg)
            ST_KSRCH:
            begin
                unit_req.a = fflg_pkg::coverage(k_reg, res5);
                unit_req.b = cfg.num_factors;
            end
            ST_CHECK:
            begin
                unit_req.a = {1'b0, column_reg};
                unit_req.b = cfg.num_factors;
            end
            ST_SIZE:
            begin
                unit_req.b = {3'b0, fflg_pkg::binom(k_reg, s_reg)};
            end
            ST_POS:
            begin
                unit_req.b = {3'b0, fflg_pkg::binom(pos_n, pos_r)};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (err_reg != fflg_pkg::ERR_OK)
            level_val = 1'b0;
        else if (gen_reg)
            level_val = ~(^(mask_reg & ~sample_reg & kmask));
        else
            level_val = sample_shift[0];
        out_mask = (err_reg == fflg_pkg::ERR_OK) ? mask_reg : '0;
        out_k    = (err_reg == fflg_pkg::ERR_K) ? '0 : k_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        column_next   = column_reg;
        k_next        = k_reg;
        s_next        = s_reg;
        p_next        = p_reg;
        x_next        = x_reg;
        g_next        = g_reg;
        mask_next     = mask_reg;
        gen_next      = gen_reg;
        err_next      = err_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        s_tready      = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sample_next = s_tdata[11:0];
                    column_next = s_tdata[23:12];
                    err_next    = fflg_pkg::ERR_OK;
                    gen_next    = 1'b0;
                    mask_next   = '0;
                    if (cfg.num_factors <= {9'b0, res_min1})
                    begin
                        k_next     = cfg.num_factors[fflg_pkg::K_W-1:0];
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        k_next     = res_min1;
                        state_next = ST_KSRCH;
                    end
                end
            end
            ST_KSRCH:
            begin
                if (!unit_rsp.lt)
                    state_next = ST_CHECK;
                else if (k_reg == fflg_pkg::K_LIMIT)
                begin
                    k_next     = k_reg + 4'd1;
                    err_next   = fflg_pkg::ERR_K;
                    state_next = ST_FINISH;
                end
                else
                    k_next = k_reg + 4'd1;
            end
            ST_CHECK:
            begin
                if (sample_oor)
                begin
                    err_next   = fflg_pkg::ERR_SAMPLE;
                    state_next = ST_FINISH;
                end
                else if (!unit_rsp.lt)
                begin
                    err_next   = fflg_pkg::ERR_COLUMN;
                    state_next = ST_FINISH;
                end
                else if (is_base)
                begin
                    mask_next  = 12'd1 << column_reg[fflg_pkg::K_W-1:0];
                    state_next = ST_FINISH;
                end
                else
                begin
                    g_next     = column_reg - {8'b0, k_reg};
                    s_next     = res_min1;
                    gen_next   = 1'b1;
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                if (s_reg > k_reg)
                    state_next = ST_FINISH;
                else if (unit_rsp.lt)
                begin
                    x_next     = '0;
                    p_next     = '0;
                    state_next = ST_POS;
                end
                else
                begin
                    g_next = unit_rsp.diff[fflg_pkg::IDX_W-1:0];
                    s_next = s_reg + 4'd1;
                end
            end
            ST_POS:
            begin
                if (p_reg == s_reg)
                    state_next = ST_FINISH;
                else
                begin
                    if (take)
                    begin
                        mask_next = mask_reg | (12'd1 << x_reg);
                        p_next    = p_reg + 4'd1;
                    end
                    else
                        g_next = unit_rsp.diff[fflg_pkg::IDX_W-1:0];
                    x_next = x_reg + 5'd1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, err_reg, out_mask, out_k, level_val};
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        column_reg  <= column_next;
        k_reg       <= k_next;
        s_reg       <= s_next;
        p_reg       <= p_next;
        x_reg       <= x_next;
        g_reg       <= g_next;
        mask_reg    <= mask_next;
        gen_reg     <= gen_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sequencer took a beat without leaving idle");

    a_kerr_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[18:17] == fflg_pkg::ERR_K |->
            m_tdata[16:1] == '0 && !m_tdata[0])
        else $error("base factor overflow result carries nonzero fields");

    a_ok_has_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[18:17] == fflg_pkg::ERR_OK |->
            m_tdata[16:5] != '0 && m_tdata[4:1] <= fflg_pkg::K_LIMIT)
        else $error("valid result without generator mask");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POS |-> x_reg <= {1'b0, k_reg} && p_reg <= s_reg)
        else $error("position walk ran past base factors");
`endif

endmodule

// File: rtl/fflg_cfg_regs.sv
// ============================================================================
// fflg_cfg_regs: APB configuration registers
// Holds num_factors and resolution; writes on the access phase, reads back.
// ============================================================================
module fflg_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output fflg_pkg::cfg_t     cfg
);

    logic [fflg_pkg::NF_W-1:0]  num_factors_reg;
    logic [fflg_pkg::RES_W-1:0] resolution_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_factors_reg <= fflg_pkg::NUM_FACTORS_RST;
            resolution_reg  <= fflg_pkg::RESOLUTION_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                fflg_pkg::REG_NUM_FACTORS: num_factors_reg <= pwdata[fflg_pkg::NF_W-1:0];
                fflg_pkg::REG_RESOLUTION:  resolution_reg  <= pwdata[fflg_pkg::RES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fflg_pkg::REG_NUM_FACTORS: prdata = {19'b0, num_factors_reg};
            fflg_pkg::REG_RESOLUTION:  prdata = {29'b0, resolution_reg};
            default:                   prdata = '0;
        endcase
    end

    assign cfg.num_factors = num_factors_reg;
    assign cfg.resolution  = resolution_reg;

endmodule

// File: rtl/fflg_sub_unit.sv
// ============================================================================
// fflg_sub_unit: shared subtract and compare unit
// Returns a - b and whether a is below b; reused by the search, check, size and position steps.
// ============================================================================
module fflg_sub_unit
(
    input  fflg_pkg::unit_req_t req,
    output fflg_pkg::unit_rsp_t rsp
);

    logic [fflg_pkg::OPD_W:0] wide;

    assign wide     = {1'b0, req.a} - {1'b0, req.b};
    assign rsp.diff = wide[fflg_pkg::OPD_W-1:0];
    assign rsp.lt   = wide[fflg_pkg::OPD_W];

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: fractional factorial level generator check
// Drives sample/column beats through the stream input under random idling on
// both sides, walks the configuration through reset, extreme and mid-range
// settings over the register port, and compares every result beat field by
// field with an independent prediction of the design-matrix entry.
// ============================================================================
module testbench;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 50;

    typedef struct packed {
        logic [fflg_pkg::ERR_W-1:0]  error_code;
        logic [fflg_pkg::MASK_W-1:0] generator_mask;
        logic [fflg_pkg::K_W-1:0]    base_factors;
        logic                        level;
    } entry_t;

    class level_board;
        fflg_pkg::cfg_t cfg;
        entry_t         expected_entries[$];
        int             mismatches;
        int             failures;

        function new();
            cfg.num_factors = fflg_pkg::NUM_FACTORS_RST;
            cfg.resolution  = fflg_pkg::RESOLUTION_RST;
            mismatches = 0;
            failures   = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == fflg_pkg::REG_NUM_FACTORS)
                cfg.num_factors = value[fflg_pkg::NF_W-1:0];
            else
                cfg.resolution = value[fflg_pkg::RES_W-1:0];
        endfunction

        function int eff_resolution();
            return (cfg.resolution == fflg_pkg::RESOLUTION_FIVE) ? 5 : 4;
        endfunction

        function longint choose(int n, int r);
            longint c;
            c = 1;
            if (r > n)
                return 0;
            for (int i = 0; i < r; i++)
                c = c * (n - i) / (i + 1);
            return c;
        endfunction

        function int base_count();
            int nf;
            int res;
            longint cov;
            nf  = cfg.num_factors;
            res = eff_resolution();
            if (nf <= res - 1)
                return nf;
            for (int k = res - 1; k < 20; k++)
            begin
                cov = k;
                for (int j = res - 1; j <= k; j++)
                    cov += choose(k, j);
                if (cov >= nf)
                    return k;
            end
            return 20;
        endfunction

        function longint generator_of(int k, int res, longint g);
            int s;
            int x;
            longint cnt;
            longint b;
            longint mask;
            mask = 0;
            for (s = res - 1; s <= k; s++)
            begin
                cnt = choose(k, s);
                if (g < cnt)
                    break;
                g -= cnt;
            end
            if (s > k)
                return 0;
            x = 0;
            for (int p = 0; p < s; p++)
            begin
                while (x < k)
                begin
                    b = choose(k - x - 1, s - p - 1);
                    if (b > g)
                        break;
                    g -= b;
                    x++;
                end
                if (x < 64)
                    mask |= longint'(1) << x;
                x++;
            end
            return mask;
        endfunction

        function entry_t predict_entry(logic [fflg_pkg::IDX_W-1:0] smp,
                                       logic [fflg_pkg::IDX_W-1:0] col);
            entry_t e;
            int k;
            int zeros;
            longint mask;
            e = '0;
            k = base_count();
            if (k > fflg_pkg::MAX_BASE_FACTORS)
            begin
                e.error_code = fflg_pkg::ERR_K;
                return e;
            end
            e.base_factors = fflg_pkg::K_W'(k);
            if (int'(smp) >= (1 << k))
            begin
                e.error_code = fflg_pkg::ERR_SAMPLE;
                return e;
            end
            if (int'(col) >= int'(cfg.num_factors))
            begin
                e.error_code = fflg_pkg::ERR_COLUMN;
                return e;
            end
            if (int'(col) < k)
            begin
                mask    = longint'(1) << col;
                e.level = smp[col];
            end
            else
            begin
                mask  = generator_of(k, eff_resolution(), longint'(col) - k);
                zeros = 0;
                for (int i = 0; i < k; i++)
                    if (mask[i] && !smp[i])
                        zeros++;
                e.level = (zeros % 2 == 0);
            end
            e.generator_mask = mask[fflg_pkg::MASK_W-1:0];
            e.error_code     = fflg_pkg::ERR_OK;
            return e;
        endfunction

        function void note_beat(logic [fflg_pkg::IDX_W-1:0] smp,
                                logic [fflg_pkg::IDX_W-1:0] col);
            expected_entries.push_back(predict_entry(smp, col));
        endfunction

        function void check_beat(logic [23:0] data);
            entry_t got;
            entry_t want;
            got = entry_t'(data[18:0]);
            if (expected_entries.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %h", data);
                return;
            end
            want = expected_entries.pop_front();
            if (got.level !== want.level || got.base_factors !== want.base_factors ||
                got.generator_mask !== want.generator_mask ||
                got.error_code !== want.error_code)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp lvl %0d k %0d mask %h err %0d, ",
                              "got lvl %0d k %0d mask %h err %0d"},
                             want.level, want.base_factors, want.generator_mask,
                             want.error_code, got.level, got.base_factors,
                             got.generator_mask, got.error_code);
            end
        endfunction

        function int pending();
            return expected_entries.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    level_board sb = new();
    int hold_cycles = 0;
    int tx_burst = 0;
    int rx_burst = 0;

    fractional_factorial_level_gen_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_beat(input logic [fflg_pkg::IDX_W-1:0] smp,
                             input logic [fflg_pkg::IDX_W-1:0] col);
        int gap;
        if (tx_burst > 0)
        begin
            gap = 0;
            tx_burst--;
        end
        else
        begin
            gap = $urandom_range(0, 17);
            if ($urandom_range(0, 11) == 0)
                tx_burst = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {col, smp};
        do @(posedge clk); while (!s_tready);
        sb.note_beat(smp, col);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic configure(input int nf, input int res);
        write_reg(fflg_pkg::REG_NUM_FACTORS, 32'(nf));
        write_reg(fflg_pkg::REG_RESOLUTION, 32'(res));
    endtask

    task automatic run_phase(input int nf, input int res, input int count, input int hold);
        int k;
        int cols;
        logic [fflg_pkg::IDX_W-1:0] smp;
        logic [fflg_pkg::IDX_W-1:0] col;
        configure(nf, res);
        if (hold > 0)
        begin
            hold_cycles = hold;
            tx_burst    = 60;
        end
        k    = sb.base_count();
        cols = (nf > 4096) ? 4096 : nf;
        for (int n = 0; n < count; n++)
        begin
            smp = fflg_pkg::IDX_W'($urandom);
            col = fflg_pkg::IDX_W'($urandom);
            if ($urandom_range(0, 4) != 0)
            begin
                if (k <= fflg_pkg::MAX_BASE_FACTORS)
                    smp = fflg_pkg::IDX_W'($urandom_range(0, (1 << k) - 1));
                if (cols > 0)
                begin
                    if (k > 0 && $urandom_range(0, 3) == 0)
                        col = fflg_pkg::IDX_W'($urandom_range(0,
                                  ((k < cols) ? k : cols) - 1));
                    else
                        col = fflg_pkg::IDX_W'($urandom_range(0, cols - 1));
                end
            end
            send_beat(smp, col);
        end
        drain();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(12'd0, 12'd0);
        send_beat(12'd1, 12'd0);
        send_beat(12'd2, 12'd0);
        send_beat(12'd4095, 12'd4095);
        send_beat(12'd0, 12'd1);
        drain();

        configure(0, 4);
        send_beat(12'd0, 12'd0);
        send_beat(12'd1, 12'd0);
        drain();

        configure(4096, 4);
        send_beat(12'd0, 12'd0);
        drain();

        configure(20, 6);
        send_beat(12'd31, 12'd4);
        send_beat(12'd10, 12'd5);
        send_beat(12'd17, 12'd19);
        send_beat(12'd0, 12'd20);
        send_beat(12'd32, 12'd5);
        drain();

        configure(11, 5);
        send_beat(12'd31, 12'd10);
        send_beat(12'd0, 12'd10);
        send_beat(12'd21, 12'd6);
        drain();

        configure(4029, 4);
        send_beat(12'd4095, 12'd4028);
        send_beat(12'd0, 12'd4028);
        send_beat(12'd2730, 12'd12);
        send_beat(12'd1365, 12'd11);
        send_beat(12'd0, 12'd4095);
        drain();

        run_phase(1, 4, 60, 0);
        run_phase(0, 4, 20, 0);
        run_phase(3, 4, 80, 0);
        run_phase(4, 5, 80, 0);
        run_phase(9, 5, 80, 0);
        run_phase(48, 4, 80, 0);
        run_phase(200, 5, 90, 400);
        run_phase(1000, 4, 150, 0);
        run_phase(3809, 5, 90, 0);
        run_phase(4096, 5, 30, 0);
        run_phase(4029, 0, 90, 0);
        run_phase(8191, 7, 20, 0);
        run_phase($urandom_range(1, 4096), $urandom_range(4, 5), 80, 0);
        run_phase($urandom_range(1, 4096), $urandom_range(4, 5), 80, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            else if (rx_burst > 0)
            begin
                gap = 0;
                rx_burst--;
            end
            else
            begin
                gap = $urandom_range(0, 17);
                if ($urandom_range(0, 11) == 0)
                    rx_burst = $urandom_range(10, 40);
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata);

    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
